// File: src/morse_code_keyer_macros.svh
// ----------------------------------------------------------------------------
// Morse code keyer assertion macros
// Shared property forms for the keyer checks, clocked on clk and
// disabled during rst.
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_KEYER_MACROS_SVH
`define MORSE_CODE_KEYER_MACROS_SVH

// Same-cycle implication.
`define MCK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyer check failed");

// Next-cycle implication.
`define MCK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyer check failed");

`endif

// File: src/mck_pkg.sv
// ----------------------------------------------------------------------------
// Morse code keyer package
// Shared constants, types, command and status records, and the Morse
// pattern lookup used by the keyer datapath and controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mck_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int MESSAGE_DEPTH = 64;
  localparam int QAW           = $clog2(QUEUE_DEPTH);
  localparam int MAW           = $clog2(MESSAGE_DEPTH);
  localparam int LEVEL_W       = 6;
  localparam int UNIT_W        = 10;
  localparam int WAIT_W        = 13;
  localparam int CFG_AW        = 3;

  localparam logic [UNIT_W-1:0] UNIT_MIN   = 10'd10;
  localparam logic [UNIT_W-1:0] UNIT_MAX   = 10'd1000;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 10'd100;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Register indexes on the configuration port.
  localparam logic REG_UNIT_TICKS  = 1'b0;
  localparam logic REG_LOOP_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ENQ    = 2'd1,
    OP_REPLAY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ON   = 3'd1,
    PH_EGAP = 3'd2,
    PH_LGAP = 3'd3,
    PH_WGAP = 3'd4
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic enqueue;
    logic rp_start;
    logic rp_read;
    logic rp_push;
    logic set_drop;
    logic wait_dec;
    logic on_end;
    logic next_elem;
    logic nc_read;
    logic nc_eval;
    logic go_idle;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t    op;
    phase_t phase;
    logic   fifo_empty;
    logic   fifo_full;
    logic   wait_zero;
    logic   msg_nonempty;
    logic   rp_last;
    logic   char_ends;
  } stat_t;

  // One result word.
  typedef struct packed {
    logic [7:0]         sending_char;
    logic               dropped;
    logic [LEVEL_W-1:0] queue_level;
    phase_t             phase;
    logic               led;
  } res_t;

  localparam logic [7:0] ALPHA_CODES [26] = '{
    8'h06, 8'h11, 8'h15, 8'h09, 8'h02, 8'h14, 8'h0B, 8'h10, 8'h04, 8'h1E,
    8'h0D, 8'h12, 8'h07, 8'h05, 8'h0F, 8'h16, 8'h1B, 8'h0A, 8'h08, 8'h03,
    8'h0C, 8'h18, 8'h0E, 8'h19, 8'h1D, 8'h13
  };

  localparam logic [7:0] DIGIT_CODES [10] = '{
    8'h3F, 8'h3E, 8'h3C, 8'h38, 8'h30, 8'h20, 8'h21, 8'h23, 8'h27, 8'h2F
  };

  function automatic logic is_word_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  // Sentinel-coded pattern of a character; zero when it has none.
  function automatic logic [7:0] code_of(input logic [7:0] c);
    logic [7:0] d;
    logic [7:0] p;
    d = '0;
    p = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      p = ALPHA_CODES[d[4:0]];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61;
      p = ALPHA_CODES[d[4:0]];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      p = DIGIT_CODES[d[3:0]];
    end else begin
      unique case (c)
        8'h2E:   p = 8'h6A;
        8'h2C:   p = 8'h73;
        8'h3F:   p = 8'h4C;
        8'h27:   p = 8'h5E;
        8'h21:   p = 8'h75;
        8'h2F:   p = 8'h29;
        8'h28:   p = 8'h2D;
        8'h29:   p = 8'h6D;
        8'h26:   p = 8'h22;
        8'h3A:   p = 8'h47;
        8'h3B:   p = 8'h55;
        8'h3D:   p = 8'h31;
        8'h2B:   p = 8'h2A;
        8'h2D:   p = 8'h61;
        8'h5F:   p = 8'h6C;
        8'h22:   p = 8'h52;
        8'h40:   p = 8'h56;
        default: p = 8'h00;
      endcase
    end
    return p;
  endfunction

  // Number of elements: position of the sentinel bit.
  function automatic logic [2:0] length_of(input logic [7:0] p);
    logic [2:0] n;
    n = '0;
    for (int i = 1; i < 8; i++) begin
      if (p[i]) n = 3'(i);
    end
    return n;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
  endfunction

endpackage

// File: src/morse_code_keyer.sv
// ----------------------------------------------------------------------------
// Morse code keyer
// Tick-driven Morse transmitter with a send FIFO, a replayable message
// store, an APB register port and streaming input and result words.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. A tick or an enqueue
// passes through the dispatch and done states up to a loaded result
// register. A tick that fetches the next character reads each FIFO entry
// in a read state and an evaluate state, since the send FIFO has one
// registered read port and unknown characters are skipped in the same
// tick; it goes idle when the FIFO runs empty. A replay, or the loop
// replay on an idle tick, copies the message a character at a time
// (message store read, then FIFO write), up to a full 63-character message,
// and stops with the drop flag set if the FIFO is full. The input is taken
// again only after the result is loaded; a waiting result register stalls
// the block in front of that load. Both stores are plain RAMs with no
// clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "morse_code_keyer_macros.svh"

module morse_code_keyer (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mck_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input words.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // char_code
  input  logic [1:0]                  s_axis_tuser,  // op
  // Result words.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // led, phase[3], queue_level[6], dropped, sending_char[8], zero pad[5]
  output logic [23:0]                 m_axis_tdata
);

  import mck_pkg::*;

  logic [UNIT_W-1:0] unit_ticks;
  logic              loop_enable;
  logic [UNIT_W-1:0] wr_unit;
  logic              cfg_write;
  cmd_t              cmd;
  stat_t             stat;
  res_t              res;
  res_t              out_res;
  logic              out_free;

  // The register port never stalls.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // The dot length saturates into its legal range on every write.
  always_comb begin
    wr_unit = pwdata[UNIT_W-1:0];
    if (wr_unit < UNIT_MIN) wr_unit = UNIT_MIN;
    if (wr_unit > UNIT_MAX) wr_unit = UNIT_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks  <= UNIT_RESET;
      loop_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_UNIT_TICKS:  unit_ticks  <= wr_unit;
        REG_LOOP_ENABLE: loop_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_UNIT_TICKS:  prdata = {{(32-UNIT_W){1'b0}}, unit_ticks};
      REG_LOOP_ENABLE: prdata = {31'b0, loop_enable};
      default:         prdata = '0;
    endcase
  end

  mck_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .out_free    (out_free),
    .loop_enable (loop_enable),
    .stat        (stat),
    .cmd         (cmd)
  );

  mck_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_op      (s_axis_tuser),
    .in_char    (s_axis_tdata),
    .unit_ticks (unit_ticks),
    .stat       (stat),
    .res        (res)
  );

  // The result register frees up in the same cycle it is taken, so the
  // controller can load the next result while the old one leaves.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_res <= res;
  end

  assign m_axis_tdata = {5'b0, out_res};

  // A result never overwrites one that is still waiting.
  `MCK_ASSERT_IMP(a_no_overwrite, cmd.out_load, out_free)
  // The block takes one word and then works on it before taking another.
  `MCK_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // The key is only down while an element is being sent.
  `MCK_ASSERT_IMP(a_led_only_on, res.led, res.phase == PH_ON)

endmodule

// File: src/mck_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/mck_datapath.sv
// ----------------------------------------------------------------------------
// Morse code keyer datapath
// Send FIFO, message store, keying registers and the gap timer, all moved
// by commands from the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mck_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  mck_pkg::cmd_t        cmd,
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_char,
  input  logic [9:0]           unit_ticks,
  output mck_pkg::stat_t       stat,
  output mck_pkg::res_t        res
);

  import mck_pkg::*;

  logic [QAW-1:0]    head;
  logic [QAW-1:0]    tail;
  logic [MAW-1:0]    msg_len;
  logic              msg_done;
  logic [MAW-1:0]    rp_idx;
  op_t               op_q;
  logic [7:0]        char_q;
  phase_t            phase;
  logic [WAIT_W-1:0] wait_cnt;
  logic [7:0]        pattern;
  logic [2:0]        elem_left;
  logic [7:0]        symbol;
  logic              led;
  logic              drop;

  logic [QAW-1:0]    head_inc;
  logic [QAW-1:0]    tail_inc;
  logic              full;
  logic [QAW:0]      level_wide;
  logic [MAW-1:0]    eff_len;
  logic              fifo_we;
  logic [7:0]        fifo_wd;
  logic [7:0]        fifo_rd;
  logic              msg_we;
  logic [7:0]        msg_rd;
  logic [WAIT_W-1:0] unit1;
  logic [WAIT_W-1:0] unit3;
  logic [WAIT_W-1:0] unit7;
  logic [7:0]        rd_code;
  logic [2:0]        rd_len;
  logic              rd_sep;

  function automatic logic [QAW-1:0] q_inc(input logic [QAW-1:0] p);
    return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_inc = q_inc(head);
  assign tail_inc = q_inc(tail);
  assign full     = (head_inc == tail);

  assign level_wide = (head >= tail) ? ({1'b0, head} - {1'b0, tail})
                                     : ({1'b0, head} + (QAW+1)'(QUEUE_DEPTH) - {1'b0, tail});

  assign unit1 = WAIT_W'(unit_ticks);
  assign unit3 = {unit1[WAIT_W-2:0], 1'b0} + unit1;
  assign unit7 = {unit1[WAIT_W-4:0], 3'b000} - unit1;

  // A finished message is replaced by the next recorded character.
  assign eff_len = msg_done ? '0 : msg_len;

  assign fifo_we = (cmd.enqueue && !full) || cmd.rp_push;
  assign fifo_wd = cmd.rp_push ? msg_rd : char_q;
  assign msg_we  = cmd.enqueue && !is_eol(char_q) && (eff_len < MAW'(MESSAGE_DEPTH - 1));

  assign rd_code = code_of(fifo_rd);
  assign rd_len  = length_of(rd_code);
  assign rd_sep  = is_word_sep(fifo_rd);

  mck_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_send_fifo (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (head),
    .wr_data (fifo_wd),
    .rd_en   (cmd.nc_read),
    .rd_addr (tail),
    .rd_data (fifo_rd)
  );

  mck_ram #(.WIDTH(8), .DEPTH(MESSAGE_DEPTH)) u_msg_store (
    .clk     (clk),
    .wr_en   (msg_we),
    .wr_addr (eff_len),
    .wr_data (char_q),
    .rd_en   (cmd.rp_read),
    .rd_addr (rp_idx),
    .rd_data (msg_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      msg_len   <= '0;
      msg_done  <= 1'b0;
      rp_idx    <= '0;
      op_q      <= OP_TICK;
      phase     <= PH_IDLE;
      wait_cnt  <= '0;
      pattern   <= '0;
      elem_left <= '0;
      symbol    <= '0;
      led       <= 1'b0;
      drop      <= 1'b0;
    end else begin
      if (cmd.capture) begin
        op_q <= op_t'(in_op);
        drop <= 1'b0;
      end
      if (cmd.enqueue) begin
        if (full) begin
          drop <= 1'b1;
        end else begin
          head <= head_inc;
        end
        if (is_eol(char_q)) begin
          if (msg_len != '0) msg_done <= 1'b1;
        end else begin
          msg_done <= 1'b0;
          if (eff_len < MAW'(MESSAGE_DEPTH - 1)) begin
            msg_len <= eff_len + 1'b1;
          end else begin
            msg_len <= eff_len;
          end
        end
      end
      if (cmd.rp_start) rp_idx <= '0;
      if (cmd.rp_push) begin
        head   <= head_inc;
        rp_idx <= rp_idx + 1'b1;
      end
      if (cmd.set_drop) drop <= 1'b1;
      if (cmd.wait_dec) wait_cnt <= wait_cnt - 1'b1;
      if (cmd.on_end) begin
        led <= 1'b0;
        if (elem_left != '0) begin
          phase    <= PH_EGAP;
          wait_cnt <= unit1;
        end else begin
          phase    <= PH_LGAP;
          wait_cnt <= unit3;
        end
      end
      if (cmd.next_elem) begin
        if (elem_left == '0) begin
          led      <= 1'b0;
          phase    <= PH_LGAP;
          wait_cnt <= unit3;
        end else begin
          pattern   <= {1'b0, pattern[7:1]};
          elem_left <= elem_left - 1'b1;
          led       <= 1'b1;
          wait_cnt  <= pattern[0] ? unit3 : unit1;
          phase     <= PH_ON;
        end
      end
      if (cmd.nc_eval) begin
        tail <= tail_inc;
        if (rd_sep) begin
          led      <= 1'b0;
          phase    <= PH_WGAP;
          wait_cnt <= unit7;
        end else if (rd_code != '0) begin
          // Load the pattern and key its first element right away.
          symbol    <= to_upper(fifo_rd);
          pattern   <= {1'b0, rd_code[7:1]};
          elem_left <= rd_len - 1'b1;
          led       <= 1'b1;
          wait_cnt  <= rd_code[0] ? unit3 : unit1;
          phase     <= PH_ON;
        end
      end
      if (cmd.go_idle) phase <= PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) char_q <= in_char;
  end

  always_comb begin
    stat.op           = op_q;
    stat.phase        = phase;
    stat.fifo_empty   = (head == tail);
    stat.fifo_full    = full;
    stat.wait_zero    = (wait_cnt == '0);
    stat.msg_nonempty = (msg_len != '0);
    stat.rp_last      = (({1'b0, rp_idx} + 1'b1) == {1'b0, msg_len});
    stat.char_ends    = rd_sep || (rd_code != '0);
  end

  always_comb begin
    res.sending_char = symbol;
    res.dropped      = drop;
    res.queue_level  = LEVEL_W'(level_wide);
    res.phase        = phase;
    res.led          = led;
  end

endmodule

// File: src/mck_ctrl.sv
// ----------------------------------------------------------------------------
// Morse code keyer controller
// Sequences one input word at a time: dispatch on the operation, walk the
// replay copy or the character fetch, then hand the result to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mck_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_free,
  input  logic            loop_enable,
  input  mck_pkg::stat_t  stat,
  output mck_pkg::cmd_t   cmd
);

  import mck_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RP_RD,
    S_RP_WR,
    S_NC_RD,
    S_NC_EVAL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        unique case (stat.op)
          OP_ENQ: begin
            cmd.enqueue = 1'b1;
          end
          OP_REPLAY: begin
            if (stat.msg_nonempty) begin
              cmd.rp_start = 1'b1;
              state_next   = S_RP_RD;
            end
          end
          OP_TICK: begin
            if (stat.phase == PH_IDLE) begin
              if (!stat.fifo_empty) begin
                state_next = S_NC_RD;
              end else if (loop_enable && stat.msg_nonempty) begin
                cmd.rp_start = 1'b1;
                state_next   = S_RP_RD;
              end
            end else if (!stat.wait_zero) begin
              cmd.wait_dec = 1'b1;
            end else begin
              unique case (stat.phase)
                PH_ON:            cmd.on_end    = 1'b1;
                PH_EGAP:          cmd.next_elem = 1'b1;
                PH_LGAP, PH_WGAP: state_next    = S_NC_RD;
                default:          cmd.go_idle   = 1'b1;
              endcase
            end
          end
          default: ;
        endcase
      end
      S_RP_RD: begin
        if (stat.fifo_full) begin
          cmd.set_drop = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.rp_read = 1'b1;
          state_next  = S_RP_WR;
        end
      end
      S_RP_WR: begin
        cmd.rp_push = 1'b1;
        state_next  = stat.rp_last ? S_DONE : S_RP_RD;
      end
      S_NC_RD: begin
        if (stat.fifo_empty) begin
          cmd.go_idle = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.nc_read = 1'b1;
          state_next  = S_NC_EVAL;
        end
      end
      S_NC_EVAL: begin
        cmd.nc_eval = 1'b1;
        state_next  = stat.char_ends ? S_DONE : S_NC_RD;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
